// ===== hdl/sample_mean_variance_defines.svh =====
// ----------------------------------------------------------------------------
// Sample mean/variance assertion macros
// Shared concurrent check templates, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_MEAN_VARIANCE_DEFINES_SVH
`define SAMPLE_MEAN_VARIANCE_DEFINES_SVH

// same-cycle implication
`define SMV_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("smv check failed: same-cycle implication");

// next-cycle implication
`define SMV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("smv check failed: next-cycle implication");

`endif

// ===== hdl/smv_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample mean/variance package
// Widths, limits and the list summary carried from the front to the back.
// ----------------------------------------------------------------------------
package smv_pkg;

   localparam int SAMPLE_WIDTH      = 16;
   localparam int COUNT_WIDTH       = 16;
   localparam int FRAC_BITS         = 16;
   localparam int MEAN_WIDTH        = 32;
   localparam int VAR_WIDTH         = 46;
   localparam int COUNT_OUT_WIDTH   = 16;

   localparam int SQR_WIDTH         = 2 * SAMPLE_WIDTH - 1;
   localparam int SUM_WIDTH         = SAMPLE_WIDTH + COUNT_WIDTH;
   localparam int SQ_WIDTH          = 2 * SAMPLE_WIDTH + COUNT_WIDTH - 2;
   localparam int ACC_WIDTH         = SQ_WIDTH + COUNT_WIDTH;
   localparam int DVD_WIDTH         = ACC_WIDTH + FRAC_BITS;
   localparam int DVS_WIDTH         = 2 * COUNT_WIDTH;
   localparam int MEAN_DVD_WIDTH    = SUM_WIDTH + FRAC_BITS;
   localparam int STEP_WIDTH        = $clog2(DVD_WIDTH + 1);
   localparam int SAT_BASE_WIDTH    = (DVD_WIDTH > MEAN_WIDTH) ? DVD_WIDTH : MEAN_WIDTH;
   localparam int SAT_WIDTH         =
      ((SAT_BASE_WIDTH > VAR_WIDTH) ? SAT_BASE_WIDTH : VAR_WIDTH) + 1;

   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_WIDTH        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCOUNT_WIDTH      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_WIDTH    = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int RSP_FIELD_WIDTH   = MEAN_WIDTH + VAR_WIDTH + COUNT_OUT_WIDTH;
   localparam int RSP_DATA_WIDTH    = ((RSP_FIELD_WIDTH + 7) / 8) * 8;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX    = '1;
   localparam logic [VAR_WIDTH-1:0]   VAR_MAX      = '1;
   localparam logic [MEAN_WIDTH-1:0]  MEAN_POS_MAX = {1'b0, {(MEAN_WIDTH - 1){1'b1}}};
   localparam logic [MEAN_WIDTH-1:0]  MEAN_NEG_MIN = {1'b1, {(MEAN_WIDTH - 1){1'b0}}};

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] sum;
      logic [SQ_WIDTH-1:0]         sq;
      logic [COUNT_WIDTH-1:0]      count;
      logic                        dropped;
   } smv_job_type;

endpackage

// ===== hdl/smv_queue.sv =====
// ----------------------------------------------------------------------------
// Sample mean/variance job queue
// Short FIFO of finished list summaries between the front and the back.
// ----------------------------------------------------------------------------
`include "sample_mean_variance_defines.svh"

module smv_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  smv_pkg::smv_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output smv_pkg::smv_job_type head_job,
   output logic                 not_empty
);
   import smv_pkg::*;

   smv_job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_WIDTH-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job  = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == QCOUNT_WIDTH'(QUEUE_DEPTH));

   `SMV_ASSERT_IMPL(a_push_has_room, push_valid, count_ff != QCOUNT_WIDTH'(QUEUE_DEPTH))
   `SMV_ASSERT_IMPL(a_pop_has_entry, pop, count_ff != '0)

endmodule

// ===== hdl/smv_front.sv =====
// ----------------------------------------------------------------------------
// Sample mean/variance front end
// Takes samples, squares them, keeps running sum, square sum and count,
// and hands a list summary to the queue on the last sample.
// ----------------------------------------------------------------------------
`include "sample_mean_variance_defines.svh"

module smv_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [smv_pkg::SAMPLE_WIDTH-1:0] in_sample,
   input  logic                                    in_last,
   input  logic                                    queue_full,
   output logic                                    push_valid,
   output smv_pkg::smv_job_type                    push_job
);
   import smv_pkg::*;

   logic                           s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] s1_sample_ff, s1_sample_in;
   logic [SQR_WIDTH-1:0]           s1_square_ff, s1_square_in;
   logic                           s1_last_ff, s1_last_in;

   logic signed [SUM_WIDTH-1:0]    sum_ff, sum_in;
   logic [SQ_WIDTH-1:0]            sq_ff, sq_in;
   logic [COUNT_WIDTH-1:0]         count_ff, count_in;
   logic                           dropped_ff, dropped_in;

   logic signed [2*SAMPLE_WIDTH-1:0] product;
   logic                             stall;
   logic                             advance;
   logic                             room;
   logic signed [SUM_WIDTH-1:0]      sum_next;
   logic [SQ_WIDTH-1:0]              sq_next;
   logic [COUNT_WIDTH-1:0]           count_next;
   logic                             dropped_next;

   assign stall    = s1_valid_ff & s1_last_ff & queue_full;
   assign in_ready = ~stall;
   assign advance  = s1_valid_ff & ~stall;
   assign product  = (2*SAMPLE_WIDTH)'(in_sample) * (2*SAMPLE_WIDTH)'(in_sample);

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      s1_square_in = s1_square_ff;
      s1_last_in   = s1_last_ff;
      if (!stall) begin
         s1_valid_in  = in_valid;
         s1_sample_in = in_sample;
         s1_square_in = SQR_WIDTH'(unsigned'(product));
         s1_last_in   = in_last;
      end
   end

   always_comb begin
      room         = (count_ff != COUNT_MAX);
      sum_next     = room ? sum_ff + SUM_WIDTH'(s1_sample_ff) : sum_ff;
      sq_next      = room ? sq_ff + SQ_WIDTH'(s1_square_ff) : sq_ff;
      count_next   = room ? count_ff + 1'b1 : count_ff;
      dropped_next = dropped_ff | ~room;

      sum_in     = sum_ff;
      sq_in      = sq_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (advance) begin
         if (s1_last_ff) begin
            sum_in     = '0;
            sq_in      = '0;
            count_in   = '0;
            dropped_in = 1'b0;
         end else begin
            sum_in     = sum_next;
            sq_in      = sq_next;
            count_in   = count_next;
            dropped_in = dropped_next;
         end
      end
   end

   assign push_valid       = advance & s1_last_ff;
   assign push_job.sum     = sum_next;
   assign push_job.sq      = sq_next;
   assign push_job.count   = count_next;
   assign push_job.dropped = dropped_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sum_ff      <= '0;
         sq_ff       <= '0;
         count_ff    <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         sum_ff      <= sum_in;
         sq_ff       <= sq_in;
         count_ff    <= count_in;
         dropped_ff  <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff <= s1_sample_in;
      s1_square_ff <= s1_square_in;
      s1_last_ff   <= s1_last_in;
   end

   `SMV_ASSERT_IMPL(a_drop_only_when_full, dropped_ff, count_ff == COUNT_MAX)
   `SMV_ASSERT_NEXT(a_clear_after_last, push_valid, count_ff == '0 && !dropped_ff)

endmodule

// ===== hdl/smv_back.sv =====
// ----------------------------------------------------------------------------
// Sample mean/variance back end
// Sequencer with a shared shift-add multiplier and restoring divider:
// mean = |sum|*2^16/n, then n*sumsq - sum^2, then variance over n^2.
// ----------------------------------------------------------------------------
`include "sample_mean_variance_defines.svh"

module smv_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     job_ready,
   input  smv_pkg::smv_job_type                     head_job,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [smv_pkg::MEAN_WIDTH-1:0]           rsp_mean,
   output logic [smv_pkg::VAR_WIDTH-1:0]            rsp_variance,
   output logic [smv_pkg::COUNT_OUT_WIDTH-1:0]      rsp_count,
   output logic                                     rsp_overflow
);
   import smv_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN_DIV,
      ST_MEAN_END,
      ST_NQ_MUL,
      ST_SQ_MUL,
      ST_VAR_START,
      ST_VAR_DIV,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic [COUNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic                    drop_ff, drop_in;
   logic [SQ_WIDTH-1:0]     sq_ff, sq_in;
   logic [SUM_WIDTH-1:0]    mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [DVS_WIDTH-1:0]    nn_ff, nn_in;
   logic [MEAN_WIDTH-1:0]   mean_ff, mean_in;
   logic [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic [ACC_WIDTH-1:0]    mul_a_ff, mul_a_in;
   logic [SUM_WIDTH-1:0]    mul_b_ff, mul_b_in;
   logic [DVD_WIDTH-1:0]    dvd_ff, dvd_in;
   logic [DVS_WIDTH-1:0]    dvs_ff, dvs_in;
   logic [DVS_WIDTH:0]      rem_ff, rem_in;
   logic [DVD_WIDTH-1:0]    quo_ff, quo_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MEAN_WIDTH-1:0]   rsp_mean_ff, rsp_mean_in;
   logic [VAR_WIDTH-1:0]    rsp_var_ff, rsp_var_in;
   logic [COUNT_OUT_WIDTH-1:0] rsp_count_ff, rsp_count_in;
   logic                    rsp_over_ff, rsp_over_in;

   logic [SUM_WIDTH-1:0]    head_mag;
   logic [DVS_WIDTH:0]      rem_shift;
   logic                    rem_ge;
   logic [DVS_WIDTH:0]      rem_step;
   logic [DVD_WIDTH-1:0]    quo_step;
   logic [DVD_WIDTH-1:0]    dvd_step;
   logic [ACC_WIDTH-1:0]    mul_term;
   logic [SAT_WIDTH-1:0]    quo_wide;
   logic [MEAN_WIDTH-1:0]   mean_sat;
   logic [VAR_WIDTH-1:0]    var_sat;
   logic                    last_step;
   logic                    out_free;

   assign head_mag  = head_job.sum[SUM_WIDTH-1] ? unsigned'(-head_job.sum)
                                                : unsigned'(head_job.sum);
   assign rem_shift = {rem_ff[DVS_WIDTH-1:0], dvd_ff[DVD_WIDTH-1]};
   assign rem_ge    = (rem_shift >= {1'b0, dvs_ff});
   assign rem_step  = rem_ge ? rem_shift - {1'b0, dvs_ff} : rem_shift;
   assign quo_step  = {quo_ff[DVD_WIDTH-2:0], rem_ge};
   assign dvd_step  = {dvd_ff[DVD_WIDTH-2:0], 1'b0};
   assign mul_term  = mul_b_ff[0] ? mul_a_ff : '0;
   assign last_step = (step_ff == STEP_WIDTH'(1));
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign quo_wide  = SAT_WIDTH'(quo_ff);

   always_comb begin
      if (neg_ff) begin
         mean_sat = (quo_wide > SAT_WIDTH'(MEAN_NEG_MIN)) ? MEAN_NEG_MIN
                                                          : -MEAN_WIDTH'(quo_ff);
      end else begin
         mean_sat = (quo_wide > SAT_WIDTH'(MEAN_POS_MAX)) ? MEAN_POS_MAX
                                                          : MEAN_WIDTH'(quo_ff);
      end
      var_sat = (quo_wide > SAT_WIDTH'(VAR_MAX)) ? VAR_MAX : VAR_WIDTH'(quo_ff);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      drop_in      = drop_ff;
      sq_in        = sq_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      nn_in        = DVS_WIDTH'(cnt_ff) * DVS_WIDTH'(cnt_ff);
      mean_in      = mean_ff;
      acc_in       = acc_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      dvd_in       = dvd_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_mean_in  = rsp_mean_ff;
      rsp_var_in   = rsp_var_ff;
      rsp_count_in = rsp_count_ff;
      rsp_over_in  = rsp_over_ff;
      pop          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (job_ready) begin
               pop      = 1'b1;
               cnt_in   = head_job.count;
               drop_in  = head_job.dropped;
               sq_in    = head_job.sq;
               mag_in   = head_mag;
               neg_in   = head_job.sum[SUM_WIDTH-1];
               dvd_in   = DVD_WIDTH'({head_mag, {FRAC_BITS{1'b0}}})
                          << (DVD_WIDTH - MEAN_DVD_WIDTH);
               dvs_in   = DVS_WIDTH'(head_job.count);
               rem_in   = '0;
               quo_in   = '0;
               step_in  = STEP_WIDTH'(MEAN_DVD_WIDTH);
               state_in = ST_MEAN_DIV;
            end
         end
         ST_MEAN_DIV: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            dvd_in  = dvd_step;
            step_in = step_ff - 1'b1;
            if (last_step) begin
               state_in = ST_MEAN_END;
            end
         end
         ST_MEAN_END: begin
            mean_in  = mean_sat;
            acc_in   = '0;
            mul_a_in = ACC_WIDTH'(sq_ff);
            mul_b_in = SUM_WIDTH'(cnt_ff);
            step_in  = STEP_WIDTH'(COUNT_WIDTH);
            state_in = ST_NQ_MUL;
         end
         ST_NQ_MUL: begin
            acc_in   = acc_ff + mul_term;
            mul_a_in = {mul_a_ff[ACC_WIDTH-2:0], 1'b0};
            mul_b_in = mul_b_ff >> 1;
            step_in  = step_ff - 1'b1;
            if (last_step) begin
               mul_a_in = ACC_WIDTH'(mag_ff);
               mul_b_in = mag_ff;
               step_in  = STEP_WIDTH'(SUM_WIDTH);
               state_in = ST_SQ_MUL;
            end
         end
         ST_SQ_MUL: begin
            acc_in   = acc_ff - mul_term;
            mul_a_in = {mul_a_ff[ACC_WIDTH-2:0], 1'b0};
            mul_b_in = mul_b_ff >> 1;
            step_in  = step_ff - 1'b1;
            if (last_step) begin
               state_in = ST_VAR_START;
            end
         end
         ST_VAR_START: begin
            dvd_in   = {acc_ff, {FRAC_BITS{1'b0}}};
            dvs_in   = nn_ff;
            rem_in   = '0;
            quo_in   = '0;
            step_in  = STEP_WIDTH'(DVD_WIDTH);
            state_in = ST_VAR_DIV;
         end
         ST_VAR_DIV: begin
            rem_in  = rem_step;
            quo_in  = quo_step;
            dvd_in  = dvd_step;
            step_in = step_ff - 1'b1;
            if (last_step) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_mean_in  = (cnt_ff == '0) ? '0 : mean_ff;
               rsp_var_in   = (cnt_ff == '0) ? '0 : var_sat;
               rsp_count_in = COUNT_OUT_WIDTH'(cnt_ff);
               rsp_over_in  = drop_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         sq_ff        <= sq_in;
         mag_ff       <= mag_in;
         neg_ff       <= neg_in;
         nn_ff        <= nn_in;
         mean_ff      <= mean_in;
         acc_ff       <= acc_in;
         mul_a_ff     <= mul_a_in;
         mul_b_ff     <= mul_b_in;
         dvd_ff       <= dvd_in;
         dvs_ff       <= dvs_in;
         rem_ff       <= rem_in;
         quo_ff       <= quo_in;
         rsp_mean_ff  <= rsp_mean_in;
         rsp_var_ff   <= rsp_var_in;
         rsp_count_ff <= rsp_count_in;
         rsp_over_ff  <= rsp_over_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_mean     = rsp_mean_ff;
   assign rsp_variance = rsp_var_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_overflow = rsp_over_ff;

   `SMV_ASSERT_IMPL(a_rem_below_divisor,
      (state_ff == ST_MEAN_DIV || state_ff == ST_VAR_DIV) && dvs_ff != '0,
      rem_ff < {1'b0, dvs_ff})

endmodule

// ===== hdl/sample_mean_variance.sv =====
// ----------------------------------------------------------------------------
// Sample mean/variance: samples stream in at one per cycle unless the front
// end stalls a list's last sample while the summary queue is full. Per list
// the back end runs the mean divide, the two shift-add products and the
// variance divide: divider and shift-add steps, one bit each.
// A two-entry summary queue lets the next lists accumulate meanwhile.
// Synchronous active-high reset clears accumulators, queue and output valid.
// ----------------------------------------------------------------------------
module sample_mean_variance (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [smv_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,   // sample
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [smv_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,   // mean, variance, sample_count
   output logic                                 rsp_tuser    // overflow
);
   import smv_pkg::*;

   logic                          push_valid;
   smv_job_type                   push_job;
   logic                          queue_full;
   logic                          pop;
   smv_job_type                   head_job;
   logic                          not_empty;
   logic [MEAN_WIDTH-1:0]         rsp_mean;
   logic [VAR_WIDTH-1:0]          rsp_variance;
   logic [COUNT_OUT_WIDTH-1:0]    rsp_count;

   smv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_sample  (signed'(req_tdata[SAMPLE_WIDTH-1:0])),
      .in_last    (req_tlast),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   smv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_job   (head_job),
      .not_empty  (not_empty)
   );

   smv_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_ready    (not_empty),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_mean     (rsp_mean),
      .rsp_variance (rsp_variance),
      .rsp_count    (rsp_count),
      .rsp_overflow (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_WIDTH'({rsp_count, rsp_variance, rsp_mean});

endmodule

// ===== tb/sv/sample_mean_variance_test.sv =====
// ----------------------------------------------------------------------------
// Sample mean/variance testbench
// Streams lists of signed samples into the block and checks every result
// (mean, population variance, sample count, overflow) against a predictor
// that sums each list exactly and divides in wide arithmetic. Covers the
// sample extremes, single-sample lists, constant lists and random lists,
// with random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sample_mean_variance_test;
   import smv_pkg::*;

   localparam int MEAN_LO   = 0;
   localparam int VAR_LO    = MEAN_LO + MEAN_WIDTH;
   localparam int COUNT_LO  = VAR_LO + VAR_WIDTH;
   localparam int STALL_MAX = 4000;
   localparam int RANDOM_ITEMS = 1900;
   localparam int CALM_ITEMS   = 1600;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct {
      logic [MEAN_WIDTH-1:0]      mean;
      logic [VAR_WIDTH-1:0]       variance;
      logic [COUNT_OUT_WIDTH-1:0] count;
      logic                       overflow;
   } list_stats_type;

   class list_stats_board_type;
      longint         acc_sum;
      longint         acc_square_sum;
      int             acc_count;
      bit             acc_dropped;
      list_stats_type pending_stats[$];
      int             errors;

      function new();
         acc_sum        = 0;
         acc_square_sum = 0;
         acc_count      = 0;
         acc_dropped    = 0;
         errors         = 0;
      endfunction

      function void note_sample(sample_type s, bit last);
         longint         x;
         longint         n;
         longint         m;
         longint         spread;
         logic [127:0]   scaled;
         logic [127:0]   q;
         list_stats_type r;
         x = s;
         if (acc_count < COUNT_MAX) begin
            acc_sum        += x;
            acc_square_sum += x * x;
            acc_count++;
         end else begin
            acc_dropped = 1;
         end
         if (!last) return;
         n = acc_count;
         if (n == 0) begin
            r.mean     = '0;
            r.variance = '0;
         end else begin
            m = (acc_sum * 65536) / n;
            if (m > 64'sd2147483647) m = 64'sd2147483647;
            if (m < -64'sd2147483648) m = -64'sd2147483648;
            r.mean = m[MEAN_WIDTH-1:0];
            spread = n * acc_square_sum - acc_sum * acc_sum;
            scaled = 128'(spread) << FRAC_BITS;
            q = scaled / (128'(n) * 128'(n));
            r.variance = (q > 128'(VAR_MAX)) ? VAR_MAX : q[VAR_WIDTH-1:0];
         end
         r.count    = acc_count[COUNT_OUT_WIDTH-1:0];
         r.overflow = acc_dropped;
         pending_stats.push_back(r);
         acc_sum        = 0;
         acc_square_sum = 0;
         acc_count      = 0;
         acc_dropped    = 0;
      endfunction

      function void check_result(logic [RSP_DATA_WIDTH-1:0] data, logic user);
         list_stats_type e;
         logic [MEAN_WIDTH-1:0]      got_mean;
         logic [VAR_WIDTH-1:0]       got_var;
         logic [COUNT_OUT_WIDTH-1:0] got_count;
         got_mean  = data[MEAN_LO +: MEAN_WIDTH];
         got_var   = data[VAR_LO +: VAR_WIDTH];
         got_count = data[COUNT_LO +: COUNT_OUT_WIDTH];
         if (pending_stats.size() == 0) begin
            $error("unexpected result: mean %0d, count %0d", $signed(got_mean), got_count);
            errors++;
            return;
         end
         e = pending_stats.pop_front();
         if (got_mean !== e.mean) begin
            $error("mean: expected %0d, got %0d", $signed(e.mean), $signed(got_mean));
            errors++;
         end
         if (got_var !== e.variance) begin
            $error("variance: expected %0d, got %0d", e.variance, got_var);
            errors++;
         end
         if (got_count !== e.count) begin
            $error("sample_count: expected %0d, got %0d", e.count, got_count);
            errors++;
         end
         if (user !== e.overflow) begin
            $error("overflow: expected %0d, got %0d", e.overflow, user);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_tvalid = 0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;   // sample
   logic                      req_tlast = 0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;        // mean, variance, sample_count
   logic                      rsp_tuser;        // overflow

   list_stats_board_type board = new();
   bit  calm = 0;
   int  idle_cycles = 0;
   int  sent = 0;

   sample_mean_variance dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_MAX) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // randomly stall the result channel, hold ready steady once calm
   initial begin
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_tready <= 1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   end

   task automatic send_sample(input sample_type s, input bit last, input bit gaps);
      if (gaps && !calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= REQ_DATA_WIDTH'($unsigned(s));
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_sample(s, last);
      sent++;
   endtask

   function automatic sample_type pick_sample();
      int choice;
      choice = $urandom_range(0, 9);
      case (choice)
         0: pick_sample = 16'sh7FFF;
         1: pick_sample = 16'sh8000;
         2: pick_sample = sample_type'($urandom_range(0, 4)) - 16'sd2;
         3, 4: pick_sample = sample_type'($urandom_range(0, 200)) - 16'sd100;
         default: pick_sample = sample_type'($urandom);
      endcase
   endfunction

   task automatic send_random_list(input int len, input bit gaps);
      for (int i = 0; i < len; i++)
         send_sample(pick_sample(), i == len - 1, gaps);
   endtask

   initial begin
      int len;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // single-sample lists at the extremes
      send_sample(16'sh7FFF, 1, 1);
      send_sample(16'sh8000, 1, 1);
      send_sample(16'sd0, 1, 1);
      send_sample(-16'sd1, 1, 1);
      // widest spread
      send_sample(16'sh7FFF, 0, 1);
      send_sample(16'sh8000, 1, 1);
      send_sample(16'sh8000, 0, 1);
      send_sample(16'sh7FFF, 0, 1);
      send_sample(16'sh8000, 0, 1);
      send_sample(16'sh7FFF, 1, 1);
      // fractional means, truncation toward zero both ways
      send_sample(-16'sd1, 0, 1);
      send_sample(-16'sd2, 1, 1);
      send_sample(16'sd1, 0, 1);
      send_sample(16'sd2, 0, 1);
      send_sample(16'sd2, 1, 1);
      send_sample(-16'sd3, 0, 1);
      send_sample(16'sd1, 0, 1);
      send_sample(16'sd1, 1, 1);
      // constant lists
      for (int i = 0; i < 3; i++) send_sample(16'sh8000, i == 2, 1);
      for (int i = 0; i < 3; i++) send_sample(16'sh7FFF, i == 2, 1);

      while (sent < RANDOM_ITEMS) begin
         if (sent >= CALM_ITEMS) calm = 1;
         case ($urandom_range(0, 19))
            0: len = $urandom_range(65, 300);
            1, 2, 3, 4: len = $urandom_range(17, 64);
            default: len = $urandom_range(1, 16);
         endcase
         send_random_list(len, 1);
      end
      req_tvalid <= 0;

      while (board.pending_stats.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== sample_mean_variance.f =====
+incdir+hdl
hdl/smv_pkg.sv
hdl/smv_queue.sv
hdl/smv_front.sv
hdl/smv_back.sv
hdl/sample_mean_variance.sv
tb/sv/sample_mean_variance_test.sv
